// ----- rtl/core/csa_pkg.sv -----
`default_nettype none
package csa_pkg;

    localparam int CSA_DATA_WIDTH = 64;
    localparam int FIELD_W        = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_OVF  = 3'd1;
    localparam logic [2:0] ST_UDF  = 3'd2;
    localparam logic [2:0] ST_DIV0 = 3'd3;
    localparam logic [2:0] ST_NMOD = 3'd4;

    localparam logic [1:0] PREC_NONE = 2'd0;
    localparam logic [1:0] PREC_MUL  = 2'd1;
    localparam logic [1:0] PREC_ADD  = 2'd2;

    // control that travels along the pipeline with each item
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic [2:0] st;
        logic       a_neg;
        logic       b_neg;
    } t_ctl;

endpackage
`default_nettype wire

// ----- rtl/core/csa_prep.sv -----
`default_nettype none
module csa_prep
    import csa_pkg::*;
#(
    parameter int W = CSA_DATA_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [2:0]           i_op,
    input  wire logic [FIELD_W-1:0]   i_a,
    input  wire logic [FIELD_W-1:0]   i_b,
    output t_ctl                      o_ctl,
    output logic      [W:0]           o_hi,
    output logic      [W-1:0]         o_lo,
    output logic      [W-1:0]         o_x
);
    t_ctl         r_ctl, n_ctl;
    logic [W:0]   r_hi;
    logic [W-1:0] r_lo, n_lo, r_x, n_x;

    logic [W-1:0] a, b, ma, mb;
    logic         a_neg, b_neg;
    logic [W:0]   sum, dif;
    logic [W-1:0] min_v;

    always_comb begin
        a     = i_a[W-1:0];
        b     = i_b[W-1:0];
        a_neg = a[W-1];
        b_neg = b[W-1];
        ma    = a_neg ? (~a + 1'b1) : a;
        mb    = b_neg ? (~b + 1'b1) : b;
        sum   = {a[W-1], a} + {b[W-1], b};
        dif   = {a[W-1], a} - {b[W-1], b};
        min_v = {1'b1, {(W-1){1'b0}}};

        n_ctl       = '0;
        n_ctl.valid = i_valid;
        n_ctl.op    = i_op;
        n_ctl.a_neg = a_neg;
        n_ctl.b_neg = b_neg;
        n_lo        = ma;
        n_x         = mb;
        case (i_op)
            OP_ADD: begin
                n_lo = sum[W-1:0];
                if (sum[W:W-1] == 2'b01) n_ctl.st = ST_OVF;
                else if (sum[W:W-1] == 2'b10) n_ctl.st = ST_UDF;
            end
            OP_SUB: begin
                n_lo = dif[W-1:0];
                if (dif[W:W-1] == 2'b01) n_ctl.st = ST_OVF;
                else if (dif[W:W-1] == 2'b10) n_ctl.st = ST_UDF;
            end
            OP_MUL: begin
                n_lo = mb;
                n_x  = ma;
            end
            OP_DIV: begin
                if (b == '0) n_ctl.st = ST_DIV0;
                else if (a == min_v && b == '1) n_ctl.st = ST_OVF;
            end
            OP_MOD: begin
                if (b_neg) n_ctl.st = ST_NMOD;
                else if (b == '0) n_ctl.st = ST_DIV0;
            end
            default: begin
                n_lo = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= n_ctl.valid;
        end
        if (i_en) begin
            r_ctl.op    <= n_ctl.op;
            r_ctl.st    <= n_ctl.st;
            r_ctl.a_neg <= n_ctl.a_neg;
            r_ctl.b_neg <= n_ctl.b_neg;
            r_hi        <= '0;
            r_lo        <= n_lo;
            r_x         <= n_x;
        end
    end

    assign o_ctl = r_ctl;
    assign o_hi  = r_hi;
    assign o_lo  = r_lo;
    assign o_x   = r_x;
endmodule
`default_nettype wire

// ----- rtl/core/csa_cell.sv -----
`default_nettype none
module csa_cell
    import csa_pkg::*;
#(
    parameter int W = CSA_DATA_WIDTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire t_ctl           i_ctl,
    input  wire logic [W:0]     i_hi,
    input  wire logic [W-1:0]   i_lo,
    input  wire logic [W-1:0]   i_x,
    output t_ctl                o_ctl,
    output logic      [W:0]     o_hi,
    output logic      [W-1:0]   o_lo,
    output logic      [W-1:0]   o_x
);
    t_ctl         r_ctl;
    logic [W:0]   r_hi, n_hi, s, t;
    logic [W-1:0] r_lo, n_lo, r_x;
    logic         ge;

    // multiply: shift-add, one multiplier bit per cell, LSB first
    // divide: restoring step, one quotient bit per cell, MSB first
    always_comb begin
        s  = i_hi + (i_lo[0] ? {1'b0, i_x} : '0);
        t  = {i_hi[W-1:0], i_lo[W-1]};
        ge = (t >= {1'b0, i_x});
        n_hi = i_hi;
        n_lo = i_lo;
        case (i_ctl.op)
            OP_MUL: begin
                n_hi = {1'b0, s[W:1]};
                n_lo = {s[0], i_lo[W-1:1]};
            end
            OP_DIV, OP_MOD: begin
                n_hi = ge ? (t - {1'b0, i_x}) : t;
                n_lo = {i_lo[W-2:0], ge};
            end
            default: begin
                n_hi = i_hi;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.op    <= i_ctl.op;
            r_ctl.st    <= i_ctl.st;
            r_ctl.a_neg <= i_ctl.a_neg;
            r_ctl.b_neg <= i_ctl.b_neg;
            r_hi        <= n_hi;
            r_lo        <= n_lo;
            r_x         <= i_x;
        end
    end

    assign o_ctl = r_ctl;
    assign o_hi  = r_hi;
    assign o_lo  = r_lo;
    assign o_x   = r_x;
endmodule
`default_nettype wire

// ----- rtl/core/csa_final.sv -----
`default_nettype none
module csa_final
    import csa_pkg::*;
#(
    parameter int W = CSA_DATA_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_ctl                 i_ctl,
    input  wire logic [W:0]           i_hi,
    input  wire logic [W-1:0]         i_lo,
    input  wire logic [W-1:0]         i_x,
    output logic                      o_valid,
    output logic      [FIELD_W-1:0]   o_value,
    output logic      [2:0]           o_status,
    output logic      [1:0]           o_prec
);
    logic                r_valid;
    logic [FIELD_W-1:0]  r_value;
    logic [2:0]          r_status, st;
    logic [1:0]          r_prec, prec;
    logic signed [W-1:0] r;
    logic                neg, hi_nz;
    logic [W-1:0]        rem;

    always_comb begin
        neg   = i_ctl.a_neg ^ i_ctl.b_neg;
        hi_nz = |i_hi[W-1:0];
        rem   = i_hi[W-1:0];
        st    = i_ctl.st;
        prec  = PREC_MUL;
        r     = '0;
        case (i_ctl.op)
            OP_ADD, OP_SUB: begin
                prec = PREC_ADD;
                r    = i_lo;
            end
            OP_MUL: begin
                if (!neg) begin
                    if (hi_nz || i_lo[W-1]) st = ST_OVF;
                    r = i_lo;
                end else begin
                    if (hi_nz || (i_lo[W-1] && (|i_lo[W-2:0]))) st = ST_UDF;
                    r = ~i_lo + 1'b1;
                end
            end
            OP_DIV: begin
                r = neg ? (~i_lo + 1'b1) : i_lo;
            end
            OP_MOD: begin
                // negative dividend: fold the remainder into 0..b-1
                r = (i_ctl.a_neg && rem != '0) ? (i_x - rem) : rem;
            end
            default: begin
                prec = PREC_NONE;
            end
        endcase
        if (st != ST_OK) r = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_value  <= FIELD_W'(r);
            r_status <= st;
            r_prec   <= prec;
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;
    assign o_prec   = r_prec;
endmodule
`default_nettype wire

// ----- rtl/core/checked_signed_alu.sv -----
// channel | dir | tdata                         | tuser
// s_      | in  | [63:0] operand_a, [127:64] b  | [2:0] req_type
// m_      | out | [63:0] result_value           | [2:0] status, [4:3] precedence
//
// One item per cycle while m_ does not stall; the pipeline is an entry stage, a row of
// DATA_WIDTH cells (one multiplier or quotient bit each), an output register.
// Reset (synchronous, active low) clears the valid bits of every stage.
// A stall on m_ freezes the whole row; s_tready follows m_tready or an empty
// output register.
`default_nettype none
module checked_signed_alu
    import csa_pkg::*;
#(
    parameter int DATA_WIDTH = CSA_DATA_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [2*FIELD_W-1:0]   s_tdata,   // operand_a, operand_b
    input  wire logic [2:0]             s_tuser,   // req_type
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [FIELD_W-1:0]     m_tdata,   // result_value
    output logic      [4:0]             m_tuser    // status, precedence
);
    localparam int W = DATA_WIDTH;

    t_ctl         ctl [0:W];
    logic [W:0]   hi  [0:W];
    logic [W-1:0] lo  [0:W];
    logic [W-1:0] x   [0:W];
    logic         en;
    logic [2:0]   status;
    logic [1:0]   prec;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    csa_prep #(.W(W)) u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_tvalid),
        .i_op(s_tuser), .i_a(s_tdata[FIELD_W-1:0]), .i_b(s_tdata[2*FIELD_W-1:FIELD_W]),
        .o_ctl(ctl[0]), .o_hi(hi[0]), .o_lo(lo[0]), .o_x(x[0])
    );

    for (genvar g = 0; g < W; g++) begin : g_cell
        csa_cell #(.W(W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(ctl[g]), .i_hi(hi[g]), .i_lo(lo[g]), .i_x(x[g]),
            .o_ctl(ctl[g+1]), .o_hi(hi[g+1]), .o_lo(lo[g+1]), .o_x(x[g+1])
        );
    end

    csa_final #(.W(W)) u_final (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_ctl(ctl[W]), .i_hi(hi[W]), .i_lo(lo[W]), .i_x(x[W]),
        .o_valid(m_tvalid), .o_value(m_tdata), .o_status(status), .o_prec(prec)
    );

    assign m_tuser = {prec, status};
endmodule
`default_nettype wire

// ----- rtl/core/csa_checker.sv -----
`default_nettype none
module csa_checker
    import csa_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [FIELD_W-1:0]   m_tdata,
    input wire logic [4:0]           m_tuser
);
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[2:0] != ST_OK |-> m_tdata == '0)
        else $error("nonzero value with error status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled item changed");

    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[4:3] == PREC_NONE |-> m_tuser[2:0] == ST_OK && m_tdata == '0)
        else $error("undefined op gave a result");

    a_div_prec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser[2:0] == ST_DIV0 || m_tuser[2:0] == ST_NMOD)
        |-> m_tuser[4:3] == PREC_MUL)
        else $error("divide status with wrong precedence");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind checked_signed_alu csa_checker u_csa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;
    import csa_pkg::*;

    localparam int LATENCY = CSA_DATA_WIDTH + 2;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  st;
        logic [1:0]  prec;
    } t_alu_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // operand_a, operand_b
    logic [2:0]   s_tuser;   // req_type
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // result_value
    logic [4:0]   m_tuser;   // status, precedence

    int error_count = 0;
    int phase = 0;          // 0 none, 1 sender idle, 2 receiver stall, 3 both
    bit hold_off = 0;
    bit timed_out = 0;

    checked_signed_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // 64-bit checked arithmetic; add, subtract and multiply use a 130-bit exact result
    function automatic t_alu_result compute_alu(input logic [2:0] op,
                                                input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        t_alu_result r;
        logic signed [129:0] wide;
        logic signed [63:0] q;
        r = '0;
        case (op)
            OP_ADD, OP_SUB, OP_MUL: begin
                r.prec = (op == OP_MUL) ? PREC_MUL : PREC_ADD;
                if (op == OP_ADD) wide = 130'(a) + 130'(b);
                else if (op == OP_SUB) wide = 130'(a) - 130'(b);
                else wide = 130'(a) * 130'(b);
                if (wide > 130'sh7FFF_FFFF_FFFF_FFFF) r.st = ST_OVF;
                else if (wide < -130'sh8000_0000_0000_0000) r.st = ST_UDF;
                else r.value = wide[63:0];
            end
            OP_DIV: begin
                r.prec = PREC_MUL;
                if (b == 0) r.st = ST_DIV0;
                else if (a == 64'sh8000_0000_0000_0000 && b == -1) r.st = ST_OVF;
                else r.value = a / b;
            end
            OP_MOD: begin
                r.prec = PREC_MUL;
                if (b < 0) r.st = ST_NMOD;
                else if (b == 0) r.st = ST_DIV0;
                else begin
                    q = a % b;
                    if (q < 0) q = q + b;
                    r.value = q;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    class t_scoreboard;
        t_alu_result pending[$];

        function void note_request(logic [2:0] op, logic [63:0] a, logic [63:0] b);
            pending.push_back(compute_alu(op, a, b));
        endfunction

        task check_result(logic [63:0] value, logic [4:0] user);
            t_alu_result want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", value, 0);
                return;
            end
            want = pending.pop_front();
            if (value !== want.value) report_mismatch("result_value", value, want.value);
            if (user[2:0] !== want.st) report_mismatch("status", user[2:0], want.st);
            if (user[4:3] !== want.prec) report_mismatch("precedence", user[4:3], want.prec);
        endtask
    endclass

    t_scoreboard scoreboard = new();

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // sample at rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) scoreboard.note_request(s_tuser, s_tdata[63:0],
                                                             s_tdata[127:64]);
            if (m_tvalid && m_tready) scoreboard.check_result(m_tdata, m_tuser);
        end
    end

    // receiver backpressure
    initial begin
        m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) m_tready <= 0;
            else if (phase == 2) m_tready <= ($urandom_range(99) >= 85);
            else if (phase == 3) m_tready <= ($urandom_range(99) >= 20);
            else m_tready <= 1;
        end
    end

    // cycles with no handshake at all
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
                idle_cycles = 0;
            else if (scoreboard.pending.size() > 0 || s_tvalid)
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) timed_out = 1;
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'(signed'($urandom_range(8)) - 4);
            3: return 64'(signed'($urandom_range(2000)) - 1000);
            4: return {32'h0, $urandom()} >> $urandom_range(31);
            5: return {{32{1'b1}}, $urandom()};
            6: return {$urandom(), $urandom()} >> $urandom_range(63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // tvalid stays high into the next item when there is no gap
    task automatic send_request(input logic [2:0] op, input logic [63:0] a,
                                input logic [63:0] b);
        int gap;
        gap = 0;
        if (phase == 1) while ($urandom_range(99) < 85) gap++;
        else if (phase == 3) while ($urandom_range(99) < 20) gap++;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {b, a};
        do @(posedge i_clk); while (!(s_tready && s_tvalid));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (scoreboard.pending.size() > 0 && !timed_out) @(negedge i_clk);
    endtask

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG1 = '1;

    initial begin
        logic [2:0] op;
        logic [63:0] a;
        logic [63:0] b;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = OP_ADD;
        i_rst_n = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;

        fork
            begin
                // directed corners
                send_request(OP_ADD, MAX64, 64'd1);
                send_request(OP_ADD, MIN64, NEG1);
                send_request(OP_ADD, MAX64, MIN64);
                send_request(OP_SUB, MIN64, 64'd1);
                send_request(OP_SUB, MAX64, NEG1);
                send_request(OP_SUB, NEG1, MAX64);
                send_request(OP_MUL, MIN64, NEG1);
                send_request(OP_MUL, MIN64, 64'd1);
                send_request(OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
                send_request(OP_MUL, 64'h1_0000_0000, 64'hFFFF_FFFF_8000_0000);
                send_request(OP_MUL, MAX64, MAX64);
                send_request(OP_MUL, 64'd0, MIN64);
                send_request(OP_DIV, MIN64, NEG1);
                send_request(OP_DIV, 64'd7, 64'd0);
                send_request(OP_DIV, -64'sd7, 64'd2);
                send_request(OP_DIV, MIN64, MAX64);
                send_request(OP_MOD, 64'd5, NEG1);
                send_request(OP_MOD, 64'd5, 64'd0);
                send_request(OP_MOD, -64'sd6, 64'd3);
                send_request(OP_MOD, -64'sd7, 64'd3);
                send_request(OP_MOD, MIN64, MAX64);
                send_request(OP_MOD, MAX64, MIN64);
                send_request(3'd5, MAX64, MAX64);
                send_request(3'd7, NEG1, NEG1);
                drain_results();

                // long receiver hold-off while the sender keeps offering items
                hold_off = 1;
                fork
                    begin
                        repeat (400) @(negedge i_clk);
                        hold_off = 0;
                    end
                    for (int k = 0; k < 150; k++)
                        send_request(3'($urandom_range(4)), pick_operand(), pick_operand());
                join
                drain_results();

                for (int p = 0; p < 4; p++) begin
                    phase = p;
                    for (int k = 0; k < 350; k++) begin
                        op = ($urandom_range(49) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(4));
                        a = pick_operand();
                        b = pick_operand();
                        send_request(op, a, b);
                    end
                    drain_results();
                end
            end
            wait (timed_out);
        join_any

        if (!timed_out) begin
            drain_results();
            repeat (LATENCY + 10) @(negedge i_clk);
        end
        if (timed_out) begin
            $display("DONE: errors detected");
        end else begin
            if (scoreboard.pending.size() != 0)
                report_mismatch("results missing", scoreboard.pending.size(), 0);
            if (error_count == 0) begin
                $display("DONE: 0 errors");
            end else begin
                $display("DONE: errors detected");
            end
        end
        $finish;
    end
endmodule
